>>> rtl/core/pmes_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmes_pkg
// Shared types and constants of the pointer motion episode segmenter.
// ----------------------------------------------------------------------------
package pmes_pkg;

  localparam int NUM_DEVICES_DEF = 8;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [23:0] IDLE_GAP_RESET = 24'd100000;
  localparam logic [19:0] USEC_PER_SEC   = 20'd1000000;
  localparam logic [15:0] SAT16          = 16'hFFFF;
  localparam logic [31:0] SAT32          = 32'hFFFF_FFFF;
  localparam logic [16:0] MAG_MAX        = 17'd46341;
  localparam logic [31:0] SQRT_BIT_INIT  = 32'h4000_0000;

  typedef enum logic [1:0] {
    REQ_MOTION = 2'd0,
    REQ_BUTTON = 2'd1,
    REQ_FLUSH  = 2'd2,
    REQ_OTHER  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    REASON_IDLE    = 2'd0,
    REASON_BUTTON  = 2'd1,
    REASON_RUN_END = 2'd2
  } reason_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_LOAD, S_CHECK, S_MEAN, S_MEANW, S_EMIT,
    S_OPEN, S_SUM, S_SQRT, S_MUL, S_DOT, S_VEL, S_VELW, S_UPD
  } bstate_t;

  typedef struct packed {
    req_t        kind;
    logic [2:0]  slot;
    logic [47:0] time_us;
    logic        has_values;
    logic [15:0] delta_x;
    logic [15:0] delta_y;
  } cmd_t;

  typedef struct packed {
    logic [47:0] start_time;
    logic [47:0] last_time;
    logic [15:0] prev_dx;
    logic [15:0] prev_dy;
    logic [15:0] move_count;
    logic        complete;
    logic [31:0] path_sum;
    logic [15:0] reversals;
    logic [31:0] peak_velocity;
    logic [47:0] velocity_sum;
    logic [15:0] velocity_count;
  } rec_t;

  typedef struct packed {
    logic [2:0]  episode_slot;
    reason_t     close_cause;
    logic [47:0] start_time;
    logic [47:0] stop_time;
    logic [15:0] move_count;
    logic        values_complete;
    logic [31:0] path_length;
    logic [15:0] reversal_count;
    logic [31:0] peak_velocity;
    logic [31:0] mean_velocity;
    logic        velocity_valid;
    logic        last;
  } out_t;

  typedef struct packed {
    logic        start;
    logic [47:0] dividend;
    logic [47:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [47:0] quotient;
  } div_rsp_t;

endpackage

>>> rtl/core/pmes_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmes_in_if
// Pointer event channel: valid, ready and one event word.
// ----------------------------------------------------------------------------
interface pmes_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [2:0]         device_slot;
  logic [47:0]        time_us;
  logic               has_values;
  logic signed [15:0] delta_x;
  logic signed [15:0] delta_y;

  modport source (output valid, req_type, device_slot, time_us, has_values,
                  delta_x, delta_y, input ready);
  modport sink   (input valid, req_type, device_slot, time_us, has_values,
                  delta_x, delta_y, output ready);
endinterface

>>> rtl/core/pmes_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmes_out_if
// Episode record channel: valid, ready and one record word.
// ----------------------------------------------------------------------------
interface pmes_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  episode_slot;
  logic [1:0]  close_cause;
  logic [47:0] start_time;
  logic [47:0] stop_time;
  logic [15:0] move_count;
  logic        values_complete;
  logic [31:0] path_length;
  logic [15:0] reversal_count;
  logic [31:0] peak_velocity;
  logic [31:0] mean_velocity;
  logic        velocity_valid;
  logic        last;

  modport source (output valid, episode_slot, close_cause, start_time, stop_time,
                  move_count, values_complete, path_length, reversal_count,
                  peak_velocity, mean_velocity, velocity_valid, last,
                  input ready);
  modport sink   (input valid, episode_slot, close_cause, start_time, stop_time,
                  move_count, values_complete, path_length, reversal_count,
                  peak_velocity, mean_velocity, velocity_valid, last,
                  output ready);
endinterface

>>> rtl/core/pmes_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmes_ram
// Generic one-write one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pmes_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;
endmodule

>>> rtl/core/pmes_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmes_div
// Restoring unsigned divider, 48 by 48 bits, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pmes_div (
  input  logic                clk,
  input  logic                rst_n,
  input  pmes_pkg::div_req_t  req,
  output pmes_pkg::div_rsp_t  rsp
);
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [47:0] rem_r, rem_nxt;
  logic [47:0] quo_r, quo_nxt;
  logic [47:0] dvs_r, dvs_nxt;
  logic [48:0] shifted;
  logic [48:0] diff;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    shifted  = {rem_r, quo_r[47]};
    diff     = shifted - {1'b0, dvs_r};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'd0;
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      if (!diff[48]) begin
        rem_nxt = diff[47:0];
        quo_nxt = {quo_r[46:0], 1'b1};
      end else begin
        rem_nxt = shifted[47:0];
        quo_nxt = {quo_r[46:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd47) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;
endmodule

>>> rtl/core/pmes_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmes_queue
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module pmes_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  pmes_pkg::cmd_t   push_cmd,
  output logic             full,
  input  logic             pop,
  output pmes_pkg::cmd_t   pop_cmd,
  output logic             not_empty
);
  localparam int PW = (pmes_pkg::QUEUE_DEPTH > 1) ? $clog2(pmes_pkg::QUEUE_DEPTH) : 1;

  pmes_pkg::cmd_t mem_r [pmes_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_r;
  logic [PW-1:0]  rd_ptr_r;
  logic [PW:0]    cnt_r;

  assign full      = (cnt_r == (PW+1)'(pmes_pkg::QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_cmd   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty) else $error("queue popped while empty");
`endif
endmodule

>>> rtl/core/pmes_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmes_front
// Accept event words, drop ignored ones, queue the rest as commands.
// ----------------------------------------------------------------------------
module pmes_front #(
  parameter int NUM_DEVICES = pmes_pkg::NUM_DEVICES_DEF
) (
  pmes_in_if.sink          in_ch,
  input  logic             full,
  output logic             push,
  output pmes_pkg::cmd_t   push_cmd
);
  localparam logic [6:0] NDEV = 7'(NUM_DEVICES);

  pmes_pkg::req_t kind;
  logic           keep;

  assign kind = pmes_pkg::req_t'(in_ch.req_type);

  always_comb begin
    case (kind)
      pmes_pkg::REQ_FLUSH:  keep = 1'b1;
      pmes_pkg::REQ_MOTION,
      pmes_pkg::REQ_BUTTON: keep = ({4'b0, in_ch.device_slot} < NDEV);
      default:              keep = 1'b0;
    endcase
  end

  assign in_ch.ready         = !full;
  assign push                = in_ch.valid && !full && keep;
  assign push_cmd.kind       = kind;
  assign push_cmd.slot       = in_ch.device_slot;
  assign push_cmd.time_us    = in_ch.time_us;
  assign push_cmd.has_values = in_ch.has_values;
  assign push_cmd.delta_x    = in_ch.delta_x;
  assign push_cmd.delta_y    = in_ch.delta_y;
endmodule

>>> rtl/core/pmes_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmes_back
// Episode sequencer: per-slot state, square root, velocity, record output.
// ----------------------------------------------------------------------------
module pmes_back #(
  parameter int NUM_DEVICES = pmes_pkg::NUM_DEVICES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  pmes_pkg::cmd_t   q_cmd,
  output logic             pop,
  input  logic             cfg_wr_en,
  input  logic [23:0]      cfg_wr_data,
  pmes_out_if.source       out_ch
);
  localparam int AW = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;

  pmes_pkg::bstate_t  state_r, state_nxt;
  pmes_pkg::cmd_t     cmd_r, cmd_nxt;
  pmes_pkg::rec_t     rec_r, rec_nxt;
  pmes_pkg::out_t     out_r, out_nxt;
  pmes_pkg::reason_t  reason_r, reason_nxt;
  pmes_pkg::div_req_t div_req;
  pmes_pkg::div_rsp_t div_rsp;

  logic [NUM_DEVICES-1:0] open_r, open_nxt;
  logic [AW:0]            scan_r, scan_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [23:0]            idle_gap_r;
  logic [31:0]            sq_r, sq_nxt;
  logic [31:0]            root_r, root_nxt;
  logic [31:0]            bit_r, bit_nxt;
  logic [31:0]            dxsq_r, dxsq_nxt;
  logic [31:0]            dysq_r, dysq_nxt;
  logic [16:0]            mag_r, mag_nxt;
  logic [36:0]            prod_r, prod_nxt;
  logic signed [31:0]     pxdx_r, pxdx_nxt;
  logic signed [31:0]     pydy_r, pydy_nxt;
  logic                   dot_neg_r, dot_neg_nxt;
  logic                   vel_do_r, vel_do_nxt;

  logic [AW-1:0]          cur_addr;
  logic [AW-1:0]          raddr;
  logic                   we;
  logic [$bits(pmes_pkg::rec_t)-1:0] rdata;
  logic [47:0]            diff48;
  logic                   vv;
  logic signed [15:0]     dxe;
  logic signed [15:0]     dye;
  logic [31:0]            trial;
  logic [32:0]            path33;
  logic [31:0]            vsat;
  logic signed [32:0]     dot33;
  logic [NUM_DEVICES-1:0] above;

  assign cur_addr = (cmd_r.kind == pmes_pkg::REQ_FLUSH) ? scan_r[AW-1:0]
                                                         : AW'(cmd_r.slot);
  assign diff48   = cmd_r.time_us - rec_r.last_time;
  assign vv       = rec_r.complete && (rec_r.velocity_count != '0);
  assign dxe      = cmd_r.has_values ? $signed(cmd_r.delta_x) : 16'sd0;
  assign dye      = cmd_r.has_values ? $signed(cmd_r.delta_y) : 16'sd0;
  assign trial    = root_r + bit_r;
  assign path33   = {1'b0, rec_r.path_sum} + 33'(mag_r);
  assign vsat     = (div_rsp.quotient[47:32] != '0) ? pmes_pkg::SAT32
                                                    : div_rsp.quotient[31:0];
  assign dot33    = pxdx_r + pydy_r;
  assign above    = (open_r >> scan_r[AW-1:0]) >> 1;

  pmes_ram #(
    .WIDTH ($bits(pmes_pkg::rec_t)),
    .DEPTH (NUM_DEVICES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (cur_addr),
    .wdata (rec_nxt),
    .raddr (raddr),
    .rdata (rdata)
  );

  pmes_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    rec_nxt       = rec_r;
    reason_nxt    = reason_r;
    open_nxt      = open_r;
    scan_nxt      = scan_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_nxt       = out_r;
    sq_nxt        = sq_r;
    root_nxt      = root_r;
    bit_nxt       = bit_r;
    dxsq_nxt      = dxsq_r;
    dysq_nxt      = dysq_r;
    mag_nxt       = mag_r;
    prod_nxt      = prod_r;
    pxdx_nxt      = pxdx_r;
    pydy_nxt      = pydy_r;
    dot_neg_nxt   = dot_neg_r;
    vel_do_nxt    = vel_do_r;
    pop           = 1'b0;
    raddr         = cur_addr;
    we            = 1'b0;
    div_req       = '0;
    case (state_r)
      pmes_pkg::S_IDLE: begin
        if (q_valid) begin
          pop     = 1'b1;
          cmd_nxt = q_cmd;
          if (q_cmd.kind == pmes_pkg::REQ_FLUSH) begin
            scan_nxt  = '0;
            state_nxt = pmes_pkg::S_SCAN;
          end else begin
            raddr     = AW'(q_cmd.slot);
            state_nxt = pmes_pkg::S_LOAD;
          end
        end
      end
      pmes_pkg::S_SCAN: begin
        if (scan_r == (AW+1)'(NUM_DEVICES)) begin
          state_nxt = pmes_pkg::S_IDLE;
        end else if (open_r[scan_r[AW-1:0]]) begin
          state_nxt = pmes_pkg::S_LOAD;
        end else begin
          scan_nxt = scan_r + (AW+1)'(1);
        end
      end
      pmes_pkg::S_LOAD: begin
        rec_nxt   = rdata;
        state_nxt = pmes_pkg::S_CHECK;
      end
      pmes_pkg::S_CHECK: begin
        case (cmd_r.kind)
          pmes_pkg::REQ_FLUSH: begin
            reason_nxt = pmes_pkg::REASON_RUN_END;
            state_nxt  = pmes_pkg::S_MEAN;
          end
          pmes_pkg::REQ_MOTION: begin
            reason_nxt = pmes_pkg::REASON_IDLE;
            if (open_r[cur_addr] && (diff48 > {24'b0, idle_gap_r})) begin
              state_nxt = pmes_pkg::S_MEAN;
            end else begin
              state_nxt = pmes_pkg::S_OPEN;
            end
          end
          default: begin
            if (!open_r[cur_addr]) begin
              state_nxt = pmes_pkg::S_IDLE;
            end else begin
              reason_nxt = (diff48 > {24'b0, idle_gap_r}) ? pmes_pkg::REASON_IDLE
                                                           : pmes_pkg::REASON_BUTTON;
              state_nxt  = pmes_pkg::S_MEAN;
            end
          end
        endcase
      end
      pmes_pkg::S_MEAN: begin
        if (vv) begin
          div_req.start    = 1'b1;
          div_req.dividend = rec_r.velocity_sum;
          div_req.divisor  = {32'b0, rec_r.velocity_count};
          state_nxt        = pmes_pkg::S_MEANW;
        end else begin
          state_nxt = pmes_pkg::S_EMIT;
        end
      end
      pmes_pkg::S_MEANW: begin
        if (div_rsp.done) begin
          state_nxt = pmes_pkg::S_EMIT;
        end
      end
      pmes_pkg::S_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt           = 1'b1;
          out_nxt.episode_slot    = 3'(cur_addr);
          out_nxt.close_cause     = reason_r;
          out_nxt.start_time      = rec_r.start_time;
          out_nxt.stop_time       = (reason_r == pmes_pkg::REASON_BUTTON) ?
                                    cmd_r.time_us : rec_r.last_time;
          out_nxt.move_count      = rec_r.move_count;
          out_nxt.values_complete = rec_r.complete;
          out_nxt.path_length     = rec_r.complete ? rec_r.path_sum : '0;
          out_nxt.reversal_count  = rec_r.complete ? rec_r.reversals : '0;
          out_nxt.peak_velocity   = vv ? rec_r.peak_velocity : '0;
          out_nxt.mean_velocity   = vv ? div_rsp.quotient[31:0] : '0;
          out_nxt.velocity_valid  = vv;
          out_nxt.last            = (cmd_r.kind == pmes_pkg::REQ_FLUSH) ?
                                    (above == '0) : 1'b1;
          open_nxt[cur_addr]      = 1'b0;
          case (cmd_r.kind)
            pmes_pkg::REQ_FLUSH: begin
              scan_nxt  = scan_r + (AW+1)'(1);
              state_nxt = pmes_pkg::S_SCAN;
            end
            pmes_pkg::REQ_MOTION: state_nxt = pmes_pkg::S_OPEN;
            default:              state_nxt = pmes_pkg::S_IDLE;
          endcase
        end
      end
      pmes_pkg::S_OPEN: begin
        if (!open_r[cur_addr]) begin
          rec_nxt                = '0;
          rec_nxt.start_time     = cmd_r.time_us;
          rec_nxt.last_time      = cmd_r.time_us;
          rec_nxt.complete       = cmd_r.has_values;
          open_nxt[cur_addr]     = 1'b1;
        end else begin
          rec_nxt.complete = rec_r.complete && cmd_r.has_values;
        end
        dxsq_nxt  = dxe * dxe;
        dysq_nxt  = dye * dye;
        state_nxt = pmes_pkg::S_SUM;
      end
      pmes_pkg::S_SUM: begin
        sq_nxt    = dxsq_r + dysq_r;
        root_nxt  = '0;
        bit_nxt   = pmes_pkg::SQRT_BIT_INIT;
        state_nxt = pmes_pkg::S_SQRT;
      end
      pmes_pkg::S_SQRT: begin
        if (bit_r != '0) begin
          if (sq_r >= trial) begin
            sq_nxt   = sq_r - trial;
            root_nxt = (root_r >> 1) + bit_r;
          end else begin
            root_nxt = root_r >> 1;
          end
          bit_nxt = bit_r >> 2;
        end else begin
          mag_nxt   = root_r[16:0] + 17'(sq_r > root_r);
          state_nxt = pmes_pkg::S_MUL;
        end
      end
      pmes_pkg::S_MUL: begin
        prod_nxt  = mag_r * pmes_pkg::USEC_PER_SEC;
        pxdx_nxt  = $signed(rec_r.prev_dx) * dxe;
        pydy_nxt  = $signed(rec_r.prev_dy) * dye;
        state_nxt = pmes_pkg::S_DOT;
      end
      pmes_pkg::S_DOT: begin
        dot_neg_nxt = dot33[32];
        state_nxt   = pmes_pkg::S_VEL;
      end
      pmes_pkg::S_VEL: begin
        if ((rec_r.move_count != '0) && (diff48 != '0)) begin
          div_req.start    = 1'b1;
          div_req.dividend = {11'b0, prod_r};
          div_req.divisor  = diff48;
          state_nxt        = pmes_pkg::S_VELW;
        end else begin
          vel_do_nxt = 1'b0;
          state_nxt  = pmes_pkg::S_UPD;
        end
      end
      pmes_pkg::S_VELW: begin
        if (div_rsp.done) begin
          vel_do_nxt = 1'b1;
          state_nxt  = pmes_pkg::S_UPD;
        end
      end
      pmes_pkg::S_UPD: begin
        rec_nxt.path_sum = path33[32] ? pmes_pkg::SAT32 : path33[31:0];
        if (rec_r.move_count != '0) begin
          if (vel_do_r) begin
            if (vsat > rec_r.peak_velocity) begin
              rec_nxt.peak_velocity = vsat;
            end
            if (rec_r.velocity_count != pmes_pkg::SAT16) begin
              rec_nxt.velocity_sum   = rec_r.velocity_sum + {16'b0, vsat};
              rec_nxt.velocity_count = rec_r.velocity_count + 16'd1;
            end
          end
          if (((rec_r.prev_dx != '0) || (rec_r.prev_dy != '0)) &&
              ((dxe != '0) || (dye != '0)) && dot_neg_r &&
              (rec_r.reversals != pmes_pkg::SAT16)) begin
            rec_nxt.reversals = rec_r.reversals + 16'd1;
          end
        end
        if (rec_r.move_count != pmes_pkg::SAT16) begin
          rec_nxt.move_count = rec_r.move_count + 16'd1;
        end
        rec_nxt.prev_dx   = dxe;
        rec_nxt.prev_dy   = dye;
        rec_nxt.last_time = cmd_r.time_us;
        we                = 1'b1;
        state_nxt         = pmes_pkg::S_IDLE;
      end
      default: state_nxt = pmes_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pmes_pkg::S_IDLE;
      open_r      <= '0;
      out_valid_r <= 1'b0;
      idle_gap_r  <= pmes_pkg::IDLE_GAP_RESET;
    end else begin
      state_r     <= state_nxt;
      open_r      <= open_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        idle_gap_r <= cfg_wr_data;
      end
    end
    cmd_r     <= cmd_nxt;
    rec_r     <= rec_nxt;
    reason_r  <= reason_nxt;
    scan_r    <= scan_nxt;
    out_r     <= out_nxt;
    sq_r      <= sq_nxt;
    root_r    <= root_nxt;
    bit_r     <= bit_nxt;
    dxsq_r    <= dxsq_nxt;
    dysq_r    <= dysq_nxt;
    mag_r     <= mag_nxt;
    prod_r    <= prod_nxt;
    pxdx_r    <= pxdx_nxt;
    pydy_r    <= pydy_nxt;
    dot_neg_r <= dot_neg_nxt;
    vel_do_r  <= vel_do_nxt;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.episode_slot    = out_r.episode_slot;
  assign out_ch.close_cause     = out_r.close_cause;
  assign out_ch.start_time      = out_r.start_time;
  assign out_ch.stop_time       = out_r.stop_time;
  assign out_ch.move_count      = out_r.move_count;
  assign out_ch.values_complete = out_r.values_complete;
  assign out_ch.path_length     = out_r.path_length;
  assign out_ch.reversal_count  = out_r.reversal_count;
  assign out_ch.peak_velocity   = out_r.peak_velocity;
  assign out_ch.mean_velocity   = out_r.mean_velocity;
  assign out_ch.velocity_valid  = out_r.velocity_valid;
  assign out_ch.last            = out_r.last;

`ifndef NO_ASSERTIONS
  a_write_open: assert property (@(posedge clk) disable iff (!rst_n)
    we |=> open_r[$past(cur_addr)]) else $error("slot written while closed");
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy) else $error("divider started while busy");
  a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pmes_pkg::S_MUL) |-> (mag_r <= pmes_pkg::MAG_MAX))
    else $error("step magnitude out of range");
`endif
endmodule

>>> rtl/core/pointer_motion_episode_segmenter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pointer_motion_episode_segmenter
// Per-slot pointer motion episodes, closed into records with path and
// velocity statistics.
// ----------------------------------------------------------------------------
// A two-entry queue decouples event intake from a sequencer that handles one
// word at a time. A motion runs a 16-step square root and a bit-serial
// divide for the step velocity, plus a read and a write of the slot
// record. Closing an episode runs the divide for the mean velocity; a flush
// scans the slots in turn. The bit-serial divider is shared by both
// divides. Per-slot records sit in a RAM of NUM_DEVICES entries with open
// bits in flip-flops; no clearing pass runs.
module pointer_motion_episode_segmenter #(
  parameter int NUM_DEVICES = pmes_pkg::NUM_DEVICES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  pmes_in_if.sink     in_ch,
  pmes_out_if.source  out_ch,
  input  logic        cfg_wr_en,
  input  logic [23:0] cfg_wr_data
);
  logic           push;
  logic           full;
  logic           pop;
  logic           not_empty;
  pmes_pkg::cmd_t push_cmd;
  pmes_pkg::cmd_t pop_cmd;

  pmes_front #(.NUM_DEVICES(NUM_DEVICES)) u_front (
    .in_ch    (in_ch),
    .full     (full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  pmes_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (full),
    .pop       (pop),
    .pop_cmd   (pop_cmd),
    .not_empty (not_empty)
  );

  pmes_back #(.NUM_DEVICES(NUM_DEVICES)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (not_empty),
    .q_cmd       (pop_cmd),
    .pop         (pop),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_ch      (out_ch)
  );
endmodule

>>> sim/pointer_motion_episode_segmenter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pointer_motion_episode_segmenter_test
// Self-checking bench for the pointer motion episode segmenter.
// ----------------------------------------------------------------------------
// Event words go in over a bursty sender and episode records come out to a
// receiver that stalls on a cycle pattern. A predictor tracks every slot's
// episode and queues the records that each accepted word should close; each
// record received is checked field by field against the oldest one queued.
// Directed cases, idle gap settings, long back-pressure and random episode
// traffic run in turn.
// ----------------------------------------------------------------------------
module pointer_motion_episode_segmenter_test;

  localparam int  NUM_SLOTS    = 8;
  localparam int  SETTLE_CYC   = 400;
  localparam int  STALL_LIMIT  = 20000;
  localparam int  HOLD_CYC     = 3000;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [23:0] cfg_wr_data;

  pmes_in_if  in_ch ();
  pmes_out_if out_ch ();

  pointer_motion_episode_segmenter DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch.sink),
    .out_ch      (out_ch.source),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // predictor state
  logic [23:0]        gap_setting;
  logic               ep_open     [NUM_SLOTS];
  logic [47:0]        ep_start    [NUM_SLOTS];
  logic [47:0]        ep_last     [NUM_SLOTS];
  int                 ep_pdx      [NUM_SLOTS];
  int                 ep_pdy      [NUM_SLOTS];
  logic [15:0]        ep_count    [NUM_SLOTS];
  logic               ep_complete [NUM_SLOTS];
  logic [31:0]        ep_path     [NUM_SLOTS];
  logic [15:0]        ep_rev      [NUM_SLOTS];
  logic [31:0]        ep_peak     [NUM_SLOTS];
  logic [63:0]        ep_vsum     [NUM_SLOTS];
  logic [15:0]        ep_vcnt     [NUM_SLOTS];

  pmes_pkg::out_t pending_records [$];
  int   mismatches;
  int   words_sent;
  int   records_checked;
  int   idle_closes;
  int   button_closes;
  int   flush_closes;
  int   burst_left;
  bit   no_gaps;
  int   hold_seq;
  int   hold_seen;
  int   hold_left;
  int   rx_cycle;
  int   quiet_cycles;
  logic [47:0] slot_clock [NUM_SLOTS];

  always #5 clk = ~clk;

  function automatic logic [63:0] root_rounded(logic [63:0] s);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'h1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    if (s > r) r = r + 64'd1;
    return r;
  endfunction

  task automatic retire_episode(int s, pmes_pkg::reason_t why, logic [47:0] end_t,
                                bit fin);
    pmes_pkg::out_t rec;
    bit   ok;
    bit   vv;
    ok = ep_complete[s];
    vv = ok && ep_vcnt[s] != 0;
    rec.episode_slot    = s[2:0];
    rec.close_cause     = why;
    rec.start_time      = ep_start[s];
    rec.stop_time       = end_t;
    rec.move_count      = ep_count[s];
    rec.values_complete = ok;
    rec.path_length     = ok ? ep_path[s] : 32'd0;
    rec.reversal_count  = ok ? ep_rev[s] : 16'd0;
    rec.peak_velocity   = vv ? ep_peak[s] : 32'd0;
    rec.mean_velocity   = vv ? 32'(ep_vsum[s] / 64'(ep_vcnt[s])) : 32'd0;
    rec.velocity_valid  = vv;
    rec.last            = fin;
    pending_records.insert(pending_records.size(), rec);
    ep_open[s] = 1'b0;
    case (why)
      pmes_pkg::REASON_IDLE:   idle_closes++;
      pmes_pkg::REASON_BUTTON: button_closes++;
      default:                 flush_closes++;
    endcase
  endtask

  task automatic add_motion(int s, logic [47:0] t, logic hv, int dx, int dy);
    logic [63:0] sq;
    logic [63:0] mag;
    logic [63:0] p;
    logic [47:0] d;
    logic [63:0] v;
    longint      dot;
    if (!hv) begin
      dx = 0;
      dy = 0;
      ep_complete[s] = 1'b0;
    end
    sq  = 64'(longint'(dx) * dx) + 64'(longint'(dy) * dy);
    mag = root_rounded(sq);
    p   = 64'(ep_path[s]) + mag;
    ep_path[s] = (p > 64'hFFFF_FFFF) ? pmes_pkg::SAT32 : p[31:0];
    if (ep_count[s] != 0) begin
      d = t - ep_last[s];
      if (d != 0) begin
        v = mag * 64'd1000000 / 64'(d);
        if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
        if (v[31:0] > ep_peak[s]) ep_peak[s] = v[31:0];
        if (ep_vcnt[s] < pmes_pkg::SAT16) begin
          ep_vsum[s] = ep_vsum[s] + v;
          ep_vcnt[s] = ep_vcnt[s] + 16'd1;
        end
      end
      if ((ep_pdx[s] != 0 || ep_pdy[s] != 0) && (dx != 0 || dy != 0)) begin
        dot = longint'(ep_pdx[s]) * dx + longint'(ep_pdy[s]) * dy;
        if (dot < 0 && ep_rev[s] < pmes_pkg::SAT16) ep_rev[s] = ep_rev[s] + 16'd1;
      end
    end
    if (ep_count[s] < pmes_pkg::SAT16) ep_count[s] = ep_count[s] + 16'd1;
    ep_pdx[s]  = dx;
    ep_pdy[s]  = dy;
    ep_last[s] = t;
  endtask

  task automatic predict_episodes(pmes_pkg::req_t kind, int s, logic [47:0] t, logic hv,
                                  logic signed [15:0] dx, logic signed [15:0] dy);
    int          fin_slot;
    bit          gapped;
    logic [47:0] since;
    if (kind == pmes_pkg::REQ_FLUSH) begin
      fin_slot = NUM_SLOTS;
      for (int k = 0; k < NUM_SLOTS; k++) if (ep_open[k]) fin_slot = k;
      for (int k = 0; k < NUM_SLOTS; k++)
        if (ep_open[k])
          retire_episode(k, pmes_pkg::REASON_RUN_END, ep_last[k], k == fin_slot);
      return;
    end
    if (kind == pmes_pkg::REQ_OTHER) return;
    since  = t - ep_last[s];
    gapped = ep_open[s] && (since > 48'(gap_setting));
    if (kind == pmes_pkg::REQ_MOTION) begin
      if (gapped) retire_episode(s, pmes_pkg::REASON_IDLE, ep_last[s], 1'b1);
      if (!ep_open[s]) begin
        ep_open[s]     = 1'b1;
        ep_start[s]    = t;
        ep_last[s]     = t;
        ep_pdx[s]      = 0;
        ep_pdy[s]      = 0;
        ep_count[s]    = '0;
        ep_complete[s] = 1'b1;
        ep_path[s]     = '0;
        ep_rev[s]      = '0;
        ep_peak[s]     = '0;
        ep_vsum[s]     = '0;
        ep_vcnt[s]     = '0;
      end
      add_motion(s, t, hv, int'(dx), int'(dy));
    end else if (ep_open[s]) begin
      if (gapped) retire_episode(s, pmes_pkg::REASON_IDLE, ep_last[s], 1'b1);
      else        retire_episode(s, pmes_pkg::REASON_BUTTON, t, 1'b1);
    end
  endtask

  // called just after a rising edge; returns after the edge that took it, or later after a pause
  task automatic send_word(pmes_pkg::req_t kind, int s, logic [47:0] t, logic hv,
                           logic signed [15:0] dx, logic signed [15:0] dy);
    int pause;
    in_ch.valid       <= 1'b1;
    in_ch.req_type    <= kind;
    in_ch.device_slot <= s[2:0];
    in_ch.time_us     <= t;
    in_ch.has_values  <= hv;
    in_ch.delta_x     <= dx;
    in_ch.delta_y     <= dy;
    do @(posedge clk); while (!in_ch.ready);
    predict_episodes(kind, s, t, hv, dx, dy);
    words_sent++;
    if (no_gaps) return;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      pause = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (pause > 0) begin
        in_ch.valid <= 1'b0;
        repeat (pause) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic settle_block();
    in_ch.valid <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_idle_gap(logic [23:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    gap_setting = value;
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h (record %0d)", what, got, want,
             records_checked);
    mismatches++;
  endtask

  task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // receiver: stall pattern, long hold-off, record check, watchdog
  always @(posedge clk) begin
    pmes_pkg::out_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_records.size() == 0) begin
          report_mismatch("unexpected record", {61'd0, out_ch.episode_slot}, 64'd0);
        end else begin
          want = pending_records.pop_front();
          check_field("episode_slot", 64'(out_ch.episode_slot), 64'(want.episode_slot));
          check_field("close_cause", 64'(out_ch.close_cause), 64'(want.close_cause));
          check_field("start_time", 64'(out_ch.start_time), 64'(want.start_time));
          check_field("stop_time", 64'(out_ch.stop_time), 64'(want.stop_time));
          check_field("move_count", 64'(out_ch.move_count), 64'(want.move_count));
          check_field("values_complete", 64'(out_ch.values_complete),
                      64'(want.values_complete));
          check_field("path_length", 64'(out_ch.path_length), 64'(want.path_length));
          check_field("reversal_count", 64'(out_ch.reversal_count),
                      64'(want.reversal_count));
          check_field("peak_velocity", 64'(out_ch.peak_velocity),
                      64'(want.peak_velocity));
          check_field("mean_velocity", 64'(out_ch.mean_velocity),
                      64'(want.mean_velocity));
          check_field("velocity_valid", 64'(out_ch.velocity_valid),
                      64'(want.velocity_valid));
          check_field("last", 64'(out_ch.last), 64'(want.last));
        end
        records_checked++;
      end
      if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", quiet_cycles);
        $display("CHECK FAILED");
        $finish;
      end
      rx_cycle++;
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYC;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case ((rx_cycle / 256) % 3)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
          default: out_ch.ready <= ((rx_cycle % 8) < 5);
        endcase
      end
    end
  end

  task automatic test_directed();
    send_word(pmes_pkg::REQ_MOTION, 0, 48'd1000, 1'b1, 16'sd32767, -16'sd32768);
    send_word(pmes_pkg::REQ_MOTION, 0, 48'd1000, 1'b1, -16'sd32768, 16'sd32767);
    send_word(pmes_pkg::REQ_MOTION, 0, 48'd1010, 1'b1, -16'sd1, 16'sd0);
    send_word(pmes_pkg::REQ_MOTION, 0, 48'd1020, 1'b0, 16'sd77, -16'sd9);
    send_word(pmes_pkg::REQ_BUTTON, 0, 48'd1030, 1'b1, 16'sd0, 16'sd0);
    send_word(pmes_pkg::REQ_BUTTON, 0, 48'd1040, 1'b0, 16'sd0, 16'sd0);
    send_word(pmes_pkg::REQ_MOTION, 1, 48'd5000, 1'b1, 16'sd100, 16'sd0);
    send_word(pmes_pkg::REQ_MOTION, 1, 48'd6000, 1'b1, -16'sd100, 16'sd0);
    send_word(pmes_pkg::REQ_MOTION, 1, 48'd106001, 1'b1, 16'sd3, 16'sd4);
    send_word(pmes_pkg::REQ_MOTION, 1, 48'd106050, 1'b1, 16'sd30, 16'sd40);
    send_word(pmes_pkg::REQ_BUTTON, 1, 48'd306051, 1'b1, 16'sd0, 16'sd0);
    send_word(pmes_pkg::REQ_MOTION, 7, 48'hFFFF_FFFF_FFF0, 1'b1, 16'sd5, 16'sd5);
    send_word(pmes_pkg::REQ_MOTION, 7, 48'h5, 1'b1, 16'sd3, 16'sd4);
    send_word(pmes_pkg::REQ_MOTION, 7, 48'h2, 1'b1, -16'sd3, -16'sd4);
    send_word(pmes_pkg::REQ_OTHER, 2, 48'hFFFF_FFFF_FFFF, 1'b1, -16'sd1, -16'sd1);
    send_word(pmes_pkg::REQ_MOTION, 2, 48'd0, 1'b1, 16'sd0, 16'sd0);
    send_word(pmes_pkg::REQ_MOTION, 3, 48'd100000, 1'b1, 16'sd1, 16'sd1);
    send_word(pmes_pkg::REQ_MOTION, 3, 48'd200000, 1'b1, -16'sd1, 16'sd1);
    send_word(pmes_pkg::REQ_FLUSH, 5, 48'd0, 1'b0, 16'sd0, 16'sd0);
    send_word(pmes_pkg::REQ_FLUSH, 0, 48'd0, 1'b0, 16'sd0, 16'sd0);
    send_word(pmes_pkg::REQ_MOTION, 4, 48'd777, 1'b1, 16'sd12, -16'sd5);
    send_word(pmes_pkg::REQ_BUTTON, 4, 48'd777, 1'b1, 16'sd0, 16'sd0);
    settle_block();
  endtask

  task automatic test_gap_extremes();
    write_idle_gap(24'd0);
    send_word(pmes_pkg::REQ_MOTION, 6, 48'd50, 1'b1, 16'sd8, 16'sd0);
    send_word(pmes_pkg::REQ_MOTION, 6, 48'd50, 1'b1, -16'sd8, 16'sd0);
    send_word(pmes_pkg::REQ_MOTION, 6, 48'd51, 1'b1, 16'sd8, 16'sd0);
    send_word(pmes_pkg::REQ_BUTTON, 6, 48'd51, 1'b1, 16'sd0, 16'sd0);
    settle_block();
    write_idle_gap(24'hFF_FFFF);
    send_word(pmes_pkg::REQ_MOTION, 6, 48'd100, 1'b1, 16'sd8, 16'sd8);
    send_word(pmes_pkg::REQ_MOTION, 6, 48'd16777315, 1'b1, 16'sd8, 16'sd8);
    send_word(pmes_pkg::REQ_MOTION, 6, 48'd33554531, 1'b1, 16'sd8, 16'sd8);
    send_word(pmes_pkg::REQ_BUTTON, 6, 48'd33554532, 1'b1, 16'sd0, 16'sd0);
    settle_block();
  endtask

  task automatic random_word(int episodes_only);
    int             pick;
    int             s;
    pmes_pkg::req_t kind;
    logic [47:0]    t;
    logic           hv;
    logic [15:0]    dx;
    logic [15:0]    dy;
    pick = $urandom_range(0, 99);
    if (pick < 72 || episodes_only != 0) kind = pmes_pkg::REQ_MOTION;
    else if (pick < 88) kind = pmes_pkg::REQ_BUTTON;
    else if (pick < 95) kind = pmes_pkg::REQ_FLUSH;
    else kind = pmes_pkg::REQ_OTHER;
    s    = $urandom_range(0, NUM_SLOTS - 1);
    pick = $urandom_range(0, 99);
    if (pick < 78)      t = slot_clock[s] + $urandom_range(0, 2000);
    else if (pick < 95) t = slot_clock[s] + gap_setting + $urandom_range(0, 3);
    else                t = 48'({$urandom, $urandom});
    slot_clock[s] = t;
    hv = ($urandom_range(0, 9) != 0);
    if ($urandom_range(0, 2) == 0) begin
      dx = 16'($urandom);
      dy = 16'($urandom);
    end else begin
      dx = 16'($signed($urandom_range(0, 64)) - 32);
      dy = 16'($signed($urandom_range(0, 64)) - 32);
    end
    send_word(kind, s, t, hv, dx, dy);
  endtask

  task automatic test_backpressure();
    hold_seq++;
    no_gaps = 1'b1;
    for (int k = 0; k < 24; k++) random_word(k % 3);
    no_gaps = 1'b0;
    send_word(pmes_pkg::REQ_FLUSH, 0, 48'd0, 1'b0, 16'sd0, 16'sd0);
    settle_block();
  endtask

  task automatic test_random();
    logic [23:0] gaps [4];
    gaps[0] = pmes_pkg::IDLE_GAP_RESET;
    gaps[1] = 24'd1500;
    gaps[2] = 24'hFF_FFFF;
    gaps[3] = 24'd0;
    for (int ph = 0; ph < 4; ph++) begin
      write_idle_gap(gaps[ph]);
      for (int k = 0; k < 90; k++) random_word(0);
      send_word(pmes_pkg::REQ_FLUSH, $urandom_range(0, 7), 48'({$urandom, $urandom}),
                1'b1, 16'sd0, 16'sd0);
      settle_block();
    end
  endtask

  initial begin
    clk         = 1'b0;
    rst_n       <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= 24'd0;
    in_ch.valid       <= 1'b0;
    in_ch.req_type    <= pmes_pkg::REQ_OTHER;
    in_ch.device_slot <= 3'd0;
    in_ch.time_us     <= 48'd0;
    in_ch.has_values  <= 1'b0;
    in_ch.delta_x     <= 16'sd0;
    in_ch.delta_y     <= 16'sd0;
    gap_setting = pmes_pkg::IDLE_GAP_RESET;
    mismatches = 0;
    words_sent = 0;
    records_checked = 0;
    idle_closes = 0;
    button_closes = 0;
    flush_closes = 0;
    burst_left = 0;
    no_gaps = 1'b0;
    hold_seq = 0;
    hold_seen = 0;
    hold_left = 0;
    rx_cycle = 0;
    quiet_cycles = 0;
    for (int k = 0; k < NUM_SLOTS; k++) begin
      ep_open[k] = 1'b0;
      ep_last[k] = 48'd0;
      slot_clock[k] = 48'd0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_gap_extremes();
    test_backpressure();
    test_random();
    $display("sent %0d event words, checked %0d episode records", words_sent,
             records_checked);
    $display("closes by idle gap %0d, button %0d, end of run %0d", idle_closes,
             button_closes, flush_closes);
    if (mismatches == 0 && pending_records.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
